@@ sv/pa_ffbf_pkg.sv @@
// Shared types and codes of the partition allocator.
// No dependencies.
`default_nettype none
package pa_ffbf_pkg;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_DUP     = 3'd1,
		ST_NOFIT   = 3'd2,
		ST_FULL    = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef enum logic {
		OP_CLAIM   = 1'b0,
		OP_RELEASE = 1'b1
	} opcode_t;

	localparam int unsigned CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MEMORY_SIZE = 1'b0,
		CFG_FIT_POLICY  = 1'b1
	} cfg_idx_t;

	localparam logic FIT_FIRST = 1'b0;

endpackage
`default_nettype wire

@@ sv/pa_ffbf_ifs.sv @@
// Request and response channels of the partition allocator.
// No dependencies.
`default_nettype none
interface pa_req_if #(
	parameter int unsigned ADDR_BITS  = 16,
	parameter int unsigned OWNER_BITS = 8
);
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [OWNER_BITS-1:0] owner_id;
	logic [ADDR_BITS-1:0]  request_size;

	modport source (output valid, opcode, owner_id, request_size, input ready);
	modport sink (input valid, opcode, owner_id, request_size, output ready);
endinterface

interface pa_rsp_if #(
	parameter int unsigned ADDR_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [2:0]           status;
	logic [ADDR_BITS-1:0] granted_start;

	modport source (output valid, status, granted_start, input ready);
	modport sink (input valid, status, granted_start, output ready);
endinterface
`default_nettype wire

@@ sv/partition_allocator_ff_bf_top.sv @@
// Partition allocator top level: partition table memory and its sequencer.
// Depends on pa_ffbf_pkg and the channel interfaces in pa_ffbf_ifs.sv.
//
// One request at a time. The partition table lives in a memory with one write
// and one registered read port; every pass streams the table through that read
// port at one entry per cycle. With N entries in use, an allocate makes a lookup
// pass over the N entries, plus a shift pass over the tail when a split of entry
// t shifts the tail up. A release makes a lookup pass, then a compaction pass that
// merges neighboring free partitions. After reset and after each write of the
// memory size register, state S_INIT rebuilds entry 0 before requests are taken.
// A finished result waits in the output register while the next request is
// accepted.
`default_nettype none
module partition_allocator_ff_bf_top #(
	parameter int unsigned ENTRY_COUNT = 64,
	parameter int unsigned ADDR_BITS   = 16,
	parameter int unsigned OWNER_BITS  = 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	pa_req_if.sink                           req,
	pa_rsp_if.source                         rsp,
	input  wire                              cfg_we,
	input  wire [pa_ffbf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire [ADDR_BITS-1:0]              cfg_data
);
	import pa_ffbf_pkg::*;

	localparam int unsigned IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int unsigned CNT_W = $clog2(ENTRY_COUNT + 1);

	typedef struct packed {
		logic [ADDR_BITS-1:0]  start;
		logic [ADDR_BITS-1:0]  len;
		logic                  free;
		logic [OWNER_BITS-1:0] owner;
	} entry_t;

	typedef enum logic [9:0] {
		S_INIT   = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_SCAN   = 10'b0000000100,
		S_DECIDE = 10'b0000001000,
		S_SHIFT  = 10'b0000010000,
		S_SPLIT  = 10'b0000100000,
		S_WRT    = 10'b0001000000,
		S_MERGE  = 10'b0010000000,
		S_MEND   = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t state_q;

	entry_t mem [ENTRY_COUNT];
	entry_t rd_q;
	logic   wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t wr_data;

	logic [ADDR_BITS-1:0]  mem_words_q;
	logic                  fit_policy_q;
	logic [CNT_W-1:0]      part_count_q;

	logic                  op_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [ADDR_BITS-1:0]  want_q;

	logic [IDX_W-1:0] iss_q, iss_last_q;
	logic             iss_on_q, iss_dn_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic                 match_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic                 pick_q;
	logic [IDX_W-1:0]     pick_idx_q;
	logic [ADDR_BITS-1:0] pick_start_q, pick_len_q, pick_left_q;
	logic                 split_q;

	entry_t           held_q;
	logic             held_vld_q;
	logic [IDX_W-1:0] w_q;

	status_t              st_q;
	logic [ADDR_BITS-1:0] gr_q;
	logic                 out_valid_q;
	status_t              out_st_q;
	logic [ADDR_BITS-1:0] out_gr_q;

	entry_t               e;
	logic [ADDR_BITS-1:0] left;
	logic                 fits;
	logic                 last;
	logic                 absorb;
	logic [IDX_W-1:0]     cnt_m1;

	assign cnt_m1 = IDX_W'(part_count_q - CNT_W'(1));
	assign last   = (rd_idx_s1 == iss_last_q);
	assign fits   = e.free && (e.len >= want_q);
	assign left   = e.len - want_q;
	assign absorb = held_vld_q && held_q.free && e.free;

	always_comb begin
		e = rd_q;
		if (state_q == S_MERGE && rd_idx_s1 == match_idx_q) begin
			e.free = 1'b1;
		end
	end

	// memory write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_INIT: begin
				wr_en         = 1'b1;
				wr_data.len   = mem_words_q;
				wr_data.free  = 1'b1;
			end
			S_SHIFT: begin
				wr_en   = rd_vld_s1;
				wr_addr = rd_idx_s1 + IDX_W'(1);
				wr_data = rd_q;
			end
			S_SPLIT: begin
				wr_en         = 1'b1;
				wr_addr       = pick_idx_q + IDX_W'(1);
				wr_data.start = pick_start_q + want_q;
				wr_data.len   = pick_len_q - want_q;
				wr_data.free  = 1'b1;
			end
			S_WRT: begin
				wr_en         = 1'b1;
				wr_addr       = pick_idx_q;
				wr_data.start = pick_start_q;
				wr_data.len   = want_q;
				wr_data.owner = owner_q;
			end
			S_MERGE: begin
				wr_en   = rd_vld_s1 && held_vld_q && !absorb;
				wr_addr = w_q;
				wr_data = held_q;
			end
			S_MEND: begin
				wr_en   = 1'b1;
				wr_addr = w_q;
				wr_data = held_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[iss_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			mem_words_q   <= '1;
			fit_policy_q  <= FIT_FIRST;
			part_count_q  <= CNT_W'(1);
			iss_q         <= '0;
			iss_last_q    <= '0;
			iss_on_q      <= 1'b0;
			iss_dn_q      <= 1'b0;
			rd_vld_s1     <= 1'b0;
			rd_idx_s1     <= '0;
			match_q       <= 1'b0;
			pick_q        <= 1'b0;
			split_q       <= 1'b0;
			held_vld_q    <= 1'b0;
			w_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= iss_on_q;
			rd_idx_s1 <= iss_q;
			if (iss_on_q) begin
				if (iss_q == iss_last_q) begin
					iss_on_q <= 1'b0;
				end else if (iss_dn_q) begin
					iss_q <= iss_q - IDX_W'(1);
				end else begin
					iss_q <= iss_q + IDX_W'(1);
				end
			end

			if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_INIT: begin
					part_count_q <= CNT_W'(1);
					state_q      <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q       <= req.opcode;
						owner_q    <= req.owner_id;
						want_q     <= req.request_size;
						match_q    <= 1'b0;
						pick_q     <= 1'b0;
						iss_q      <= '0;
						iss_last_q <= cnt_m1;
						iss_dn_q   <= 1'b0;
						iss_on_q   <= 1'b1;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_vld_s1) begin
						if (!match_q && !e.free && e.owner == owner_q) begin
							match_q     <= 1'b1;
							match_idx_q <= rd_idx_s1;
						end
						if (fits && (!pick_q ||
						    (fit_policy_q != FIT_FIRST && left < pick_left_q))) begin
							pick_q       <= 1'b1;
							pick_idx_q   <= rd_idx_s1;
							pick_start_q <= e.start;
							pick_len_q   <= e.len;
							pick_left_q  <= left;
						end
						if (last) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					gr_q <= '0;
					if (op_q == OP_RELEASE) begin
						if (!match_q) begin
							st_q    <= ST_UNKNOWN;
							state_q <= S_DONE;
						end else begin
							held_vld_q <= 1'b0;
							w_q        <= '0;
							iss_q      <= '0;
							iss_last_q <= cnt_m1;
							iss_dn_q   <= 1'b0;
							iss_on_q   <= 1'b1;
							state_q    <= S_MERGE;
						end
					end else if (match_q) begin
						st_q    <= ST_DUP;
						state_q <= S_DONE;
					end else if (!pick_q) begin
						st_q    <= ST_NOFIT;
						state_q <= S_DONE;
					end else if (pick_len_q > want_q) begin
						split_q <= 1'b1;
						if (part_count_q == CNT_W'(ENTRY_COUNT)) begin
							st_q    <= ST_FULL;
							state_q <= S_DONE;
						end else if (cnt_m1 == pick_idx_q) begin
							state_q <= S_SPLIT;
						end else begin
							iss_q      <= cnt_m1;
							iss_last_q <= pick_idx_q + IDX_W'(1);
							iss_dn_q   <= 1'b1;
							iss_on_q   <= 1'b1;
							state_q    <= S_SHIFT;
						end
					end else begin
						split_q <= 1'b0;
						state_q <= S_WRT;
					end
				end
				S_SHIFT: begin
					if (rd_vld_s1 && last) begin
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					state_q <= S_WRT;
				end
				S_WRT: begin
					if (split_q) begin
						part_count_q <= part_count_q + CNT_W'(1);
					end
					st_q    <= ST_OK;
					gr_q    <= pick_start_q;
					state_q <= S_DONE;
				end
				S_MERGE: begin
					if (rd_vld_s1) begin
						if (absorb) begin
							held_q.len <= held_q.len + e.len;
						end else begin
							if (held_vld_q) begin
								w_q <= w_q + IDX_W'(1);
							end
							held_q     <= e;
							held_vld_q <= 1'b1;
						end
						if (last) begin
							state_q <= S_MEND;
						end
					end
				end
				S_MEND: begin
					part_count_q <= CNT_W'(w_q) + CNT_W'(1);
					st_q         <= ST_OK;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_st_q    <= st_q;
						out_gr_q    <= gr_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase

			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_MEMORY_SIZE: begin
						mem_words_q <= cfg_data;
						state_q     <= S_INIT;
					end
					CFG_FIT_POLICY: fit_policy_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_st_q;
	assign rsp.granted_start = out_gr_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		part_count_q != '0 && part_count_q <= CNT_W'(ENTRY_COUNT))
		else $error("partition count out of range");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q != ST_OK |-> out_gr_q == '0)
		else $error("grant on failed request");

	a_shift_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> part_count_q < CNT_W'(ENTRY_COUNT))
		else $error("shift with full table");

	a_one_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");

	a_split_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRT && split_q |=> part_count_q == $past(part_count_q) + CNT_W'(1))
		else $error("split did not grow table");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for partition_allocator_ff_bf_top.
// Drives allocate/release items, predicts status and granted start from a local
// partition table model, checks every response. Depends on pa_ffbf_pkg and the interfaces.
`default_nettype none
module testbench;
	import pa_ffbf_pkg::*;

	typedef struct packed {
		opcode_t     op;
		logic [7:0]  owner;
		logic [15:0] size;
	} req_item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] start;
	} rsp_item_t;

	localparam int ENTRIES = 64;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_idx;
	logic [15:0] cfg_data;

	pa_req_if #(.ADDR_BITS(16), .OWNER_BITS(8)) req ();
	pa_rsp_if #(.ADDR_BITS(16)) rsp ();

	partition_allocator_ff_bf_top #(.ENTRY_COUNT(ENTRIES), .ADDR_BITS(16), .OWNER_BITS(8)) DUT (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// predicted partition table
	logic [15:0] mem_size;
	logic        best_fit;
	logic [15:0] tbl_start [ENTRIES];
	logic [15:0] tbl_len [ENTRIES];
	logic        tbl_free [ENTRIES];
	logic [7:0]  tbl_owner [ENTRIES];
	int          tbl_count;

	req_item_t pending_reqs[$];
	rsp_item_t expected_rsps[$];
	int        send_idle_pct;
	int        recv_idle_pct;
	int        hold_cycles;
	int        errors;
	int        accepted;
	logic      req_hs;

	function automatic void table_clear();
		tbl_start[0] = '0;
		tbl_len[0] = mem_size;
		tbl_free[0] = 1'b1;
		tbl_owner[0] = '0;
		tbl_count = 1;
	endfunction

	function automatic int owner_slot(logic [7:0] owner);
		for (int i = 0; i < tbl_count; i++)
			if (!tbl_free[i] && tbl_owner[i] == owner)
				return i;
		return ENTRIES;
	endfunction

	function automatic rsp_item_t predict_response(req_item_t it);
		rsp_item_t r;
		int pick;
		int w;
		logic [15:0] best_left;
		r.status = ST_OK;
		r.start = '0;
		pick = ENTRIES;
		best_left = '0;
		if (it.op == OP_CLAIM) begin
			if (owner_slot(it.owner) != ENTRIES) begin
				r.status = ST_DUP;
				return r;
			end
			for (int i = 0; i < tbl_count; i++) begin
				if (!tbl_free[i] || tbl_len[i] < it.size)
					continue;
				if (!best_fit) begin
					pick = i;
					break;
				end
				if (pick == ENTRIES || tbl_len[i] - it.size < best_left) begin
					pick = i;
					best_left = tbl_len[i] - it.size;
				end
			end
			if (pick == ENTRIES) begin
				r.status = ST_NOFIT;
				return r;
			end
			if (tbl_len[pick] > it.size) begin
				if (tbl_count >= ENTRIES) begin
					r.status = ST_FULL;
					return r;
				end
				for (int k = tbl_count; k > pick + 1; k--) begin
					tbl_start[k] = tbl_start[k-1];
					tbl_len[k] = tbl_len[k-1];
					tbl_free[k] = tbl_free[k-1];
					tbl_owner[k] = tbl_owner[k-1];
				end
				tbl_start[pick+1] = tbl_start[pick] + it.size;
				tbl_len[pick+1] = tbl_len[pick] - it.size;
				tbl_free[pick+1] = 1'b1;
				tbl_owner[pick+1] = '0;
				tbl_count++;
			end
			tbl_len[pick] = it.size;
			tbl_free[pick] = 1'b0;
			tbl_owner[pick] = it.owner;
			r.start = tbl_start[pick];
		end else begin
			pick = owner_slot(it.owner);
			if (pick == ENTRIES) begin
				r.status = ST_UNKNOWN;
				return r;
			end
			tbl_free[pick] = 1'b1;
			tbl_owner[pick] = '0;
			w = 0;
			for (int i = 0; i < tbl_count; i++) begin
				if (w > 0 && tbl_free[w-1] && tbl_free[i]) begin
					tbl_len[w-1] = tbl_len[w-1] + tbl_len[i];
					continue;
				end
				tbl_start[w] = tbl_start[i];
				tbl_len[w] = tbl_len[i];
				tbl_free[w] = tbl_free[i];
				tbl_owner[w] = tbl_owner[i];
				w++;
			end
			tbl_count = w;
		end
		return r;
	endfunction

	function automatic void push_req(opcode_t op, logic [7:0] owner, logic [15:0] size);
		req_item_t it;
		it.op = op;
		it.owner = owner;
		it.size = size;
		pending_reqs.push_back(it);
	endfunction

	function automatic logic [15:0] rand_size(logic [15:0] limit);
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'($urandom);
			default: return 16'($urandom_range(1, (limit < 16) ? 16 : limit / 8));
		endcase
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_idx_t idx, logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MEMORY_SIZE) begin
			mem_size = data;
			table_clear();
		end else begin
			best_fit = data[0];
		end
	endtask

	// random phase: mostly allocate/release of a small owner pool
	task automatic random_phase(int n, logic [15:0] limit);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0: push_req(opcode_t'($urandom_range(0, 1)), 8'($urandom), 16'($urandom));
				1, 2, 3, 4, 5, 6, 7, 8, 9:
					push_req(OP_CLAIM, 8'($urandom_range(0, 40)), rand_size(limit));
				default: push_req(OP_RELEASE, 8'($urandom_range(0, 40)), 16'($urandom));
			endcase
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("simulation failed");
		$finish;
	end

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (req.valid && !req_hs) begin
		end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
			req_item_t it;
			it = pending_reqs.pop_front();
			req.valid <= 1'b1;
			req.opcode <= it.op;
			req.owner_id <= it.owner;
			req.request_size <= it.size;
		end else begin
			req.valid <= 1'b0;
		end
	end

	// receiver stall control
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= $urandom_range(0, 99) >= recv_idle_pct;
		end
	end

	// monitor
	always @(posedge clk) begin
		req_hs <= arst_n && req.valid && req.ready;
		if (arst_n && req.valid && req.ready) begin
			req_item_t it;
			it.op = opcode_t'(req.opcode);
			it.owner = req.owner_id;
			it.size = req.request_size;
			expected_rsps.push_back(predict_response(it));
			accepted++;
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response status=%0d start=%0d",
					$time, rsp.status, rsp.granted_start);
				errors++;
			end else begin
				rsp_item_t e;
				e = expected_rsps.pop_front();
				if (rsp.status !== e.status || rsp.granted_start !== e.start) begin
					$display("%0t: expected status=%0d start=%0d, actual status=%0d start=%0d",
						$time, e.status, e.start, rsp.status, rsp.granted_start);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		accepted = 0;
		hold_cycles = 0;
		send_idle_pct = 30;
		recv_idle_pct = 85;
		cfg_we = 1'b0;
		cfg_idx = CFG_MEMORY_SIZE;
		cfg_data = '0;
		req.valid = 1'b0;
		req.opcode = 1'b0;
		req.owner_id = '0;
		req.request_size = '0;
		rsp.ready = 1'b0;
		mem_size = 16'hFFFF;
		best_fit = FIT_FIRST;
		table_clear();
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(posedge clk);

		// directed: dup, zero size, exact fit, unknown owner, no fit, merges
		push_req(OP_CLAIM, 8'd0, 16'd0);
		push_req(OP_CLAIM, 8'd255, 16'd100);
		push_req(OP_CLAIM, 8'd255, 16'd5);
		push_req(OP_CLAIM, 8'd1, 16'hFFFF);
		push_req(OP_CLAIM, 8'd2, 16'd200);
		push_req(OP_CLAIM, 8'd3, 16'd300);
		push_req(OP_RELEASE, 8'd255, 16'hFFFF);
		push_req(OP_RELEASE, 8'd3, 16'd0);
		push_req(OP_CLAIM, 8'd4, 16'd100);
		push_req(OP_RELEASE, 8'd77, 16'd0);
		push_req(OP_RELEASE, 8'd2, 16'd0);
		push_req(OP_CLAIM, 8'd5, 16'hFFFF - 16'd100);
		push_req(OP_RELEASE, 8'd0, 16'd0);
		push_req(OP_RELEASE, 8'd4, 16'd0);
		push_req(OP_RELEASE, 8'd5, 16'd0);
		push_req(OP_CLAIM, 8'd6, 16'hFFFF);
		push_req(OP_RELEASE, 8'd6, 16'd0);
		wait_drained();

		// table full: many 1-word pieces in a small memory
		write_cfg(CFG_MEMORY_SIZE, 16'd100);
		for (int i = 0; i < 66; i++)
			push_req(OP_CLAIM, 8'(i + 10), 16'd1);
		wait_drained();

		// zero memory, best fit
		write_cfg(CFG_MEMORY_SIZE, 16'd0);
		write_cfg(CFG_FIT_POLICY, 16'd1);
		push_req(OP_CLAIM, 8'd1, 16'd1);
		push_req(OP_CLAIM, 8'd1, 16'd0);
		push_req(OP_RELEASE, 8'd1, 16'd0);
		wait_drained();

		// pressure: long receiver hold-off while items keep coming
		send_idle_pct = 0;
		write_cfg(CFG_MEMORY_SIZE, 16'd1000);
		random_phase(30, 16'd1000);
		@(negedge clk);
		hold_cycles = 3000;
		wait_drained();

		send_idle_pct = 30;
		recv_idle_pct = 85;
		write_cfg(CFG_FIT_POLICY, 16'd0);
		write_cfg(CFG_MEMORY_SIZE, 16'd500);
		random_phase(220, 16'd500);
		wait_drained();
		write_cfg(CFG_FIT_POLICY, 16'd1);
		random_phase(220, 16'd500);
		wait_drained();

		send_idle_pct = 85;
		recv_idle_pct = 30;
		write_cfg(CFG_MEMORY_SIZE, 16'hFFFF);
		random_phase(220, 16'hFFFF);
		wait_drained();
		write_cfg(CFG_FIT_POLICY, 16'd0);
		random_phase(220, 16'hFFFF);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_cfg(CFG_MEMORY_SIZE, 16'd1);
		random_phase(60, 16'd1);
		wait_drained();
		write_cfg(CFG_MEMORY_SIZE, 16'd4096);
		write_cfg(CFG_FIT_POLICY, 16'd1);
		random_phase(250, 16'd4096);
		wait_drained();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
